// ----- rtl/twce_pkg.sv -----
// Package for the text window cursor engine: state encoding, command codes,
// register indexes, control characters and sizing constants. No dependencies.
package twce_pkg;

    localparam int TAB_STOP    = 8;
    localparam int MAX_RESULTS = 24;

    localparam int K_W    = $clog2(TAB_STOP + 1);
    localparam int CNT_W  = $clog2(MAX_RESULTS + 1);

    typedef logic [2:0] t_cmd;
    localparam t_cmd CMD_WRITE  = 3'd0;
    localparam t_cmd CMD_SCROLL = 3'd1;
    localparam t_cmd CMD_BELL   = 3'd2;
    localparam t_cmd CMD_CURSOR = 3'd3;
    localparam t_cmd CMD_NOWIN  = 3'd4;

    typedef logic [2:0] t_cfg_idx;
    localparam t_cfg_idx CFG_WINDOW    = 3'd0;
    localparam t_cfg_idx CFG_ATTRIBUTE = 3'd1;
    localparam t_cfg_idx CFG_LEFT      = 3'd2;
    localparam t_cfg_idx CFG_TOP       = 3'd3;
    localparam t_cfg_idx CFG_LAST_COL  = 3'd4;
    localparam t_cfg_idx CFG_LAST_ROW  = 3'd5;

    localparam logic [7:0] CH_BELL  = 8'd7;
    localparam logic [7:0] CH_BS    = 8'd8;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_NOWIN,
        S_BELL,
        S_LF_CHECK,
        S_WRAP,
        S_SCROLL,
        S_WRITE,
        S_CURSOR
    } t_state;

endpackage

// ----- rtl/text_window_cursor_engine_core.sv -----
// Text window cursor engine: character in, console commands out.
// Depends on twce_pkg (constants, command codes, state type).
//
//  channel | direction | handshake                     | payload
//  --------+-----------+-------------------------------+----------------------------------
//  in      | request   | i_in_valid / o_in_stall       | i_char_code
//  out     | result    | o_out_valid / i_out_stall     | o_command, o_screen_column,
//          |           |                               | o_screen_row, o_cell_value,
//          |           |                               | o_last_of_run
//  cfg     | write     | i_cfg_we                      | i_cfg_index, i_cfg_data
//
// A request is taken only in the idle state; o_in_stall is high while the
// sequencer works on it. After dispatch, no-window ends in the no-window
// state; carriage return and backspace go to the cursor state, line feed via
// the line-feed check and bell via the bell state; a printing character
// takes one wrap, scroll, write and cursor pass, a tab one per space. Steps
// that emit wait while the result register is held by i_out_stall.
// Reset (synchronous, i_rst_n low) clears the cursor, the output register
// valid and loads the register defaults. Results beyond the per-character
// cap are dropped without waiting on the output side.
module text_window_cursor_engine_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // request channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [7:0]            i_char_code,
    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output twce_pkg::t_cmd        o_command,
    output logic [7:0]            o_screen_column,
    output logic [7:0]            o_screen_row,
    output logic [15:0]           o_cell_value,
    output logic                  o_last_of_run,
    // configuration write port
    input  logic                  i_cfg_we,
    input  twce_pkg::t_cfg_idx    i_cfg_index,
    input  logic [7:0]            i_cfg_data
);
    import twce_pkg::*;

    // configuration registers
    logic       r_window;
    logic [7:0] r_attr;
    logic [7:0] r_left;
    logic [7:0] r_top;
    logic [7:0] r_last_col;
    logic [7:0] r_last_row;

    // architectural cursor
    logic [7:0] r_cur_col, n_cur_col;
    logic [7:0] r_cur_row, n_cur_row;

    // sequencer working registers
    t_state            r_state, n_state;
    logic [7:0]        r_char, n_char;
    logic [8:0]        r_x, n_x;
    logic [8:0]        r_y, n_y;
    logic [K_W-1:0]    r_k, n_k;
    logic [CNT_W-1:0]  r_cnt, n_cnt;

    // output register
    logic        r_ovalid, n_ovalid;
    t_cmd        r_ocmd, n_ocmd;
    logic [7:0]  r_ocol, n_ocol;
    logic [7:0]  r_orow, n_orow;
    logic [15:0] r_ocell, n_ocell;
    logic        r_olast, n_olast;

    logic             out_free;
    logic             cap_open;
    logic             emit_ok;
    logic [7:0]       clamp_x;

    assign o_in_stall      = (r_state != S_IDLE);
    assign o_out_valid     = r_ovalid;
    assign o_command       = r_ocmd;
    assign o_screen_column = r_ocol;
    assign o_screen_row    = r_orow;
    assign o_cell_value    = r_ocell;
    assign o_last_of_run   = r_olast;

    // output register may take a new result when empty or being drained
    assign out_free  = !r_ovalid || !i_out_stall;
    // results past the cap are dropped, so such a step never waits
    assign cap_open  = (r_cnt < CNT_W'(MAX_RESULTS));
    assign emit_ok   = out_free || !cap_open;
    // cursor column clamped to the window for the hardware cursor
    assign clamp_x   = (r_x > {1'b0, r_last_col}) ? r_last_col : r_x[7:0];

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window   <= 1'b0;
            r_attr     <= 8'd7;
            r_left     <= 8'd0;
            r_top      <= 8'd0;
            r_last_col <= 8'd79;
            r_last_row <= 8'd24;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_WINDOW:    r_window   <= i_cfg_data[0];
                CFG_ATTRIBUTE: r_attr     <= i_cfg_data;
                CFG_LEFT:      r_left     <= i_cfg_data;
                CFG_TOP:       r_top      <= i_cfg_data;
                CFG_LAST_COL:  r_last_col <= i_cfg_data;
                CFG_LAST_ROW:  r_last_row <= i_cfg_data;
                default:       ;
            endcase
        end
    end

    // state register and control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cur_col <= '0;
            r_cur_row <= '0;
            r_ovalid  <= 1'b0;
            r_cnt     <= '0;
        end else begin
            r_state   <= n_state;
            r_cur_col <= n_cur_col;
            r_cur_row <= n_cur_row;
            r_ovalid  <= n_ovalid;
            r_cnt     <= n_cnt;
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_char  <= n_char;
        r_x     <= n_x;
        r_y     <= n_y;
        r_k     <= n_k;
        r_ocmd  <= n_ocmd;
        r_ocol  <= n_ocol;
        r_orow  <= n_orow;
        r_ocell <= n_ocell;
        r_olast <= n_olast;
    end

    always_comb begin
        n_state   = r_state;
        n_cur_col = r_cur_col;
        n_cur_row = r_cur_row;
        n_char    = r_char;
        n_x       = r_x;
        n_y       = r_y;
        n_k       = r_k;
        n_cnt     = r_cnt;
        n_ovalid  = r_ovalid && i_out_stall;
        n_ocmd    = r_ocmd;
        n_ocol    = r_ocol;
        n_orow    = r_orow;
        n_ocell   = r_ocell;
        n_olast   = r_olast;

        unique case (r_state)
            S_IDLE: begin
                // capture the request and start from the stored cursor
                if (i_in_valid) begin
                    n_char  = i_char_code;
                    n_x     = {1'b0, r_cur_col};
                    n_y     = {1'b0, r_cur_row};
                    n_k     = K_W'(1);
                    n_cnt   = '0;
                    n_state = S_DISPATCH;
                end
            end

            S_DISPATCH: begin
                if (!r_window) begin
                    n_state = S_NOWIN;
                end else begin
                    unique case (r_char)
                        CH_CR: begin
                            n_x     = '0;
                            n_state = S_CURSOR;
                        end
                        CH_LF: begin
                            n_y     = r_y + 9'd1;
                            n_state = S_LF_CHECK;
                        end
                        CH_BS: begin
                            if (r_x != 9'd0) begin
                                n_x = r_x - 9'd1;
                            end
                            n_state = S_CURSOR;
                        end
                        CH_BELL: begin
                            n_state = S_BELL;
                        end
                        CH_TAB: begin
                            // spaces up to the next tab stop, then one print pass each
                            n_char  = CH_SPACE;
                            n_k     = K_W'(TAB_STOP) - K_W'(r_x[7:0] % TAB_STOP);
                            n_state = S_WRAP;
                        end
                        default: begin
                            n_state = S_WRAP;
                        end
                    endcase
                end
            end

            S_NOWIN: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_ocmd   = CMD_NOWIN;
                    n_ocol   = '0;
                    n_orow   = '0;
                    n_ocell  = '0;
                    n_olast  = 1'b1;
                    n_state  = S_IDLE;
                end
            end

            S_BELL: begin
                if (emit_ok) begin
                    if (cap_open) begin
                        n_ovalid = 1'b1;
                        n_ocmd   = CMD_BELL;
                        n_ocol   = '0;
                        n_orow   = '0;
                        n_ocell  = '0;
                        n_olast  = 1'b0;
                        n_cnt    = r_cnt + CNT_W'(1);
                    end
                    n_state = S_CURSOR;
                end
            end

            S_LF_CHECK: begin
                if (r_y > {1'b0, r_last_row}) begin
                    if (emit_ok) begin
                        if (cap_open) begin
                            n_ovalid = 1'b1;
                            n_ocmd   = CMD_SCROLL;
                            n_ocol   = '0;
                            n_orow   = '0;
                            n_ocell  = {r_attr, CH_SPACE};
                            n_olast  = (r_cnt == CNT_W'(MAX_RESULTS - 1));
                            n_cnt    = r_cnt + CNT_W'(1);
                        end
                        n_y     = {1'b0, r_last_row};
                        n_state = S_CURSOR;
                    end
                end else begin
                    n_state = S_CURSOR;
                end
            end

            S_WRAP: begin
                // a pending wrap moves to the start of the next row
                if (r_x > {1'b0, r_last_col}) begin
                    n_x = '0;
                    n_y = r_y + 9'd1;
                end
                n_state = S_SCROLL;
            end

            S_SCROLL: begin
                if (r_y > {1'b0, r_last_row}) begin
                    if (emit_ok) begin
                        if (cap_open) begin
                            n_ovalid = 1'b1;
                            n_ocmd   = CMD_SCROLL;
                            n_ocol   = '0;
                            n_orow   = '0;
                            n_ocell  = {r_attr, CH_SPACE};
                            n_olast  = (r_cnt == CNT_W'(MAX_RESULTS - 1));
                            n_cnt    = r_cnt + CNT_W'(1);
                        end
                        n_y     = {1'b0, r_last_row};
                        n_state = S_WRITE;
                    end
                end else begin
                    n_state = S_WRITE;
                end
            end

            S_WRITE: begin
                if (emit_ok) begin
                    if (cap_open) begin
                        n_ovalid = 1'b1;
                        n_ocmd   = CMD_WRITE;
                        n_ocol   = r_left + r_x[7:0];
                        n_orow   = r_top + r_y[7:0];
                        n_ocell  = {r_attr, r_char};
                        n_olast  = (r_cnt == CNT_W'(MAX_RESULTS - 1));
                        n_cnt    = r_cnt + CNT_W'(1);
                    end
                    n_x     = r_x + 9'd1;
                    n_state = S_CURSOR;
                end
            end

            S_CURSOR: begin
                if (emit_ok) begin
                    if (cap_open) begin
                        n_ovalid = 1'b1;
                        n_ocmd   = CMD_CURSOR;
                        n_ocol   = r_left + clamp_x;
                        n_orow   = r_top + r_y[7:0];
                        n_ocell  = '0;
                        n_olast  = (r_k == K_W'(1)) ||
                                   (r_cnt == CNT_W'(MAX_RESULTS - 1));
                        n_cnt    = r_cnt + CNT_W'(1);
                    end
                    // commit the cursor; a column of 256 folds to 0
                    n_cur_col = r_x[7:0];
                    n_cur_row = r_y[7:0];
                    n_x       = {1'b0, r_x[7:0]};
                    n_y       = {1'b0, r_y[7:0]};
                    if (r_k == K_W'(1)) begin
                        n_state = S_IDLE;
                    end else begin
                        n_k     = r_k - K_W'(1);
                        n_state = S_WRAP;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
